/* hdl/lfea_pkg.sv */
// Shared types and constants for the largest-fit extent allocator.
package lfea_pkg;

	localparam int AW = 30;

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_GROW  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOSPACE = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_UNKNOWN = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_ROT,
		CELL_WRITE,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SLOT,
		S_FIND,
		S_SCAN,
		S_EVAL,
		S_APPLY2,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [AW-1:0] start;
		logic [AW-1:0] len;
	} ext_t;

	typedef struct packed {
		cell_op_t op;
		ext_t     val;
	} cell_cmd_t;

	localparam logic [AW-1:0] HDR_BYTES  = 30'd16;
	localparam logic [AW:0]   MIN_EXTENT = 31'd24;

endpackage

/* hdl/lfea_cell.sv */
// One free-extent cell of the sorted extent chain.
module lfea_cell
	import lfea_pkg::*;
#(
	parameter int              IW      = 6,
	parameter int              K       = 0,
	parameter logic [AW-1:0]   RST_LEN = '0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_cmd_t     cmd,
	input  logic [IW-1:0] idx,
	input  ext_t          left,
	input  ext_t          right,
	output ext_t          ext
);

	localparam logic [IW-1:0] MY_IDX = IW'(K);

	ext_t ext_q;

	// shift, rotate or overwrite per the broadcast command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q.start <= '0;
			ext_q.len   <= RST_LEN;
		end else begin
			case (cmd.op)
				CELL_ROT: ext_q <= right;
				CELL_WRITE: begin
					if (MY_IDX == idx) ext_q <= cmd.val;
				end
				CELL_INSERT: begin
					if (MY_IDX > idx) ext_q <= left;
					else if (MY_IDX == idx) ext_q <= cmd.val;
				end
				CELL_REMOVE: begin
					if (MY_IDX >= idx) ext_q <= right;
				end
				default: ext_q <= ext_q;
			endcase
		end
	end

	assign ext = ext_q;

endmodule

/* hdl/lfea_ram.sv */
// Single-port-write, single-port-read RAM with registered read data.
module lfea_ram #(
	parameter int W = 60,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* hdl/largest_fit_extent_allocator_unit.sv */
// Largest-fit extent allocator: free extents in a rotating cell chain, allocations in RAM.
// Allocate runs a free-slot scan, then one full rotation of the extent chain; free and grow run
// a handle lookup over the allocation RAM, then a rotation. One item at a time; the next item
// is taken in the cycle its result shows on done, which the receiver cannot stall.
// Reset: one free extent covering the region, no live allocations, all slots invalid.
module largest_fit_extent_allocator_unit
	import lfea_pkg::*;
#(
	parameter int REGION_BYTES     = 536870912,
	parameter int MAX_FREE_EXTENTS = 64,
	parameter int MAX_LIVE_ALLOCS  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [29:0] request_bytes,
	input  logic [28:0] handle,
	output logic        done,
	output logic [1:0]  status,
	output logic [28:0] granted_offset,
	output logic [29:0] free_total,
	output logic [8:0]  live_count,
	output logic [6:0]  free_extent_count
);

	localparam int N  = MAX_FREE_EXTENTS;
	localparam int M  = MAX_LIVE_ALLOCS;
	localparam int IW = $clog2(N);
	localparam int EW = $clog2(N + 1);
	localparam int SW = $clog2(M);
	localparam int LW = $clog2(M + 1);

	state_t state_q, state_d;

	// item registers
	kind_t       kind_q;
	logic [29:0] req_q;
	logic [28:0] hnd_q;
	logic [30:0] need_q;

	// allocator state
	logic [M-1:0]  valid_q;
	logic [LW-1:0] live_q;
	logic [EW-1:0] ext_q;
	logic [29:0]   total_q;

	// scan state
	logic [SW-1:0] slot_q;
	logic [SW:0]   a_q;
	logic [SW-1:0] a_s1;
	logic          rv_s1, v_s1;
	logic [IW-1:0] rc_q;
	logic          f_q;
	logic [IW-1:0] x_idx_q;
	logic [29:0]   x_start_q, x_len_q, p_start_q, p_len_q;
	logic [EW-1:0] pos_q;
	logic [29:0]   s_q, sl_q, oreq_q;
	logic [32:0]   gsz_q;

	// result registers
	stat_t       stat_q;
	logic [28:0] granted_q;
	logic        done_q;

	// cell chain
	ext_t          cells [N];
	cell_cmd_t     cmd;
	logic [IW-1:0] cidx;

	// memories
	logic          span_we, req_we;
	logic [59:0]   span_wd, span_rd;
	logic [29:0]   req_rd;
	logic [SW-1:0] raddr;
	ext_t          span_r;

	assign span_r = ext_t'(span_rd);

	for (genvar k = 0; k < N; k++) begin : g_cell
		ext_t lft;
		if (k == 0) begin : g_first
			assign lft = '0;
		end else begin : g_rest
			assign lft = cells[k-1];
		end
		lfea_cell #(
			.IW(IW), .K(k), .RST_LEN((k == 0) ? AW'(REGION_BYTES) : '0)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .idx(cidx),
			.left(lft), .right(cells[(k + 1) % N]), .ext(cells[k])
		);
	end

	lfea_ram #(.W(60), .D(M)) u_span (
		.clk(clk), .we(span_we), .waddr(slot_q), .wdata(span_wd),
		.raddr(raddr), .rdata(span_rd)
	);

	lfea_ram #(.W(30), .D(M)) u_req (
		.clk(clk), .we(req_we), .waddr(slot_q), .wdata(req_q),
		.raddr(raddr), .rdata(req_rd)
	);

	assign raddr = a_q[SW-1:0];

	// lookup and evaluation terms
	ext_t        head;
	logic        in_rng, match, last_rd;
	logic [29:0] e_w;
	logic [30:0] a_left;
	logic        a_whole;
	logic        mp, mn;
	logic [32:0] goal, xend, g_rem;
	logic        g_ok, g_whole;

	assign head    = cells[0];
	assign in_rng  = EW'(rc_q) < ext_q;
	assign match   = rv_s1 && v_s1 && ({1'b0, span_r.start} + {1'b0, HDR_BYTES}) == {2'b0, hnd_q};
	assign last_rd = rv_s1 && (a_s1 == SW'(M - 1));
	assign e_w     = s_q + sl_q;
	assign a_left  = {1'b0, x_len_q} - need_q;
	assign a_whole = a_left < MIN_EXTENT;
	assign mp      = (pos_q != '0) && (p_start_q + p_len_q == s_q);
	assign mn      = f_q && (x_start_q == e_w);
	assign goal    = {3'b0, s_q} + gsz_q;
	assign xend    = {3'b0, e_w} + {3'b0, x_len_q};
	assign g_ok    = f_q && (x_start_q == e_w) && (goal <= xend);
	assign g_rem   = xend - goal;
	assign g_whole = g_rem < {2'b0, MIN_EXTENT};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (kind_t'(kind))
						KIND_ALLOC: state_d = (live_q >= LW'(M)) ? S_DONE : S_SLOT;
						KIND_FREE:  state_d = (handle == '0) ? S_DONE : S_FIND;
						KIND_GROW:  state_d = S_FIND;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_SLOT: if (!valid_q[slot_q]) state_d = S_SCAN;
			S_FIND: begin
				if (match) state_d = (kind_q == KIND_GROW && req_rd >= req_q) ? S_DONE : S_SCAN;
				else if (last_rd) state_d = S_DONE;
			end
			S_SCAN: if (rc_q == IW'(N - 1)) state_d = S_EVAL;
			S_EVAL: state_d = (kind_q == KIND_FREE && mp && mn) ? S_APPLY2 : S_DONE;
			S_APPLY2: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// cell commands and memory writes
	always_comb begin
		cmd.op  = CELL_HOLD;
		cmd.val = '0;
		cidx    = x_idx_q;
		span_we = 1'b0;
		span_wd = {s_q, sl_q};
		req_we  = 1'b0;
		case (state_q)
			S_SCAN: cmd.op = CELL_ROT;
			S_EVAL: begin
				case (kind_q)
					KIND_ALLOC: begin
						if (f_q) begin
							span_we = 1'b1;
							req_we  = 1'b1;
							if (a_whole) begin
								cmd.op  = CELL_REMOVE;
								span_wd = {x_start_q, x_len_q};
							end else begin
								cmd.op        = CELL_WRITE;
								cmd.val.start = x_start_q + need_q[29:0];
								cmd.val.len   = a_left[29:0];
								span_wd       = {x_start_q, need_q[29:0]};
							end
						end
					end
					KIND_FREE: begin
						if (mp) begin
							cmd.op        = CELL_WRITE;
							cidx          = IW'(pos_q - EW'(1));
							cmd.val.start = p_start_q;
							cmd.val.len   = mn ? (p_len_q + sl_q + x_len_q) : (p_len_q + sl_q);
						end else if (mn) begin
							cmd.op        = CELL_WRITE;
							cmd.val.start = s_q;
							cmd.val.len   = x_len_q + sl_q;
						end else if (ext_q < EW'(N)) begin
							cmd.op        = CELL_INSERT;
							cidx          = IW'(pos_q);
							cmd.val.start = s_q;
							cmd.val.len   = sl_q;
						end
					end
					KIND_GROW: begin
						if (g_ok) begin
							span_we = 1'b1;
							req_we  = 1'b1;
							if (g_whole) begin
								cmd.op  = CELL_REMOVE;
								span_wd = {s_q, sl_q + x_len_q};
							end else begin
								cmd.op        = CELL_WRITE;
								cmd.val.start = goal[29:0];
								cmd.val.len   = g_rem[29:0];
								span_wd       = {s_q, gsz_q[29:0]};
							end
						end
					end
					default: ;
				endcase
			end
			S_APPLY2: begin
				cmd.op = CELL_REMOVE;
				cidx   = IW'(pos_q);
			end
			default: ;
		endcase
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kind_q    <= KIND_NONE;
			req_q     <= '0;
			hnd_q     <= '0;
			need_q    <= '0;
			valid_q   <= '0;
			live_q    <= '0;
			ext_q     <= EW'(1);
			total_q   <= 30'(REGION_BYTES);
			slot_q    <= '0;
			a_q       <= '0;
			a_s1      <= '0;
			rv_s1     <= 1'b0;
			v_s1      <= 1'b0;
			rc_q      <= '0;
			f_q       <= 1'b0;
			x_idx_q   <= '0;
			x_start_q <= '0;
			x_len_q   <= '0;
			p_start_q <= '0;
			p_len_q   <= '0;
			pos_q     <= '0;
			s_q       <= '0;
			sl_q      <= '0;
			oreq_q    <= '0;
			gsz_q     <= '0;
			stat_q    <= STAT_OK;
			granted_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_DONE);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q    <= kind_t'(kind);
						req_q     <= request_bytes;
						hnd_q     <= handle;
						need_q    <= ({1'b0, request_bytes} + 31'd31) & ~31'd7;
						granted_q <= '0;
						stat_q    <= (kind_t'(kind) == KIND_ALLOC && live_q >= LW'(M))
							? STAT_FULL : STAT_OK;
						slot_q    <= '0;
						a_q       <= '0;
						rv_s1     <= 1'b0;
						rc_q      <= '0;
						f_q       <= 1'b0;
						pos_q     <= '0;
					end
				end
				// first invalid slot
				S_SLOT: if (valid_q[slot_q]) slot_q <= slot_q + SW'(1);
				// handle lookup through the allocation RAM
				S_FIND: begin
					if (a_q < (SW+1)'(M)) a_q <= a_q + (SW+1)'(1);
					rv_s1 <= a_q < (SW+1)'(M);
					v_s1  <= valid_q[a_q[SW-1:0]];
					a_s1  <= a_q[SW-1:0];
					if (match) begin
						slot_q <= a_s1;
						s_q    <= span_r.start;
						sl_q   <= span_r.len;
						oreq_q <= req_rd;
					end else if (last_rd) begin
						stat_q <= STAT_UNKNOWN;
					end
				end
				// one full rotation of the extent chain
				S_SCAN: begin
					rc_q  <= rc_q + IW'(1);
					gsz_q <= ({3'b0, sl_q} + {3'b0, req_q} - {3'b0, oreq_q} + 33'd7) & ~33'd7;
					if (in_rng) begin
						case (kind_q)
							KIND_ALLOC: begin
								if ({1'b0, head.len} >= need_q && (!f_q || head.len > x_len_q)) begin
									f_q       <= 1'b1;
									x_idx_q   <= rc_q;
									x_start_q <= head.start;
									x_len_q   <= head.len;
								end
							end
							KIND_FREE: begin
								if (head.start <= s_q) begin
									pos_q     <= EW'(rc_q) + EW'(1);
									p_start_q <= head.start;
									p_len_q   <= head.len;
								end else if (!f_q) begin
									f_q       <= 1'b1;
									x_idx_q   <= rc_q;
									x_start_q <= head.start;
									x_len_q   <= head.len;
								end
							end
							KIND_GROW: begin
								if (!f_q && head.start >= e_w) begin
									f_q       <= 1'b1;
									x_idx_q   <= rc_q;
									x_start_q <= head.start;
									x_len_q   <= head.len;
								end
							end
							default: ;
						endcase
					end
				end
				// apply the decision
				S_EVAL: begin
					case (kind_q)
						KIND_ALLOC: begin
							if (!f_q) begin
								stat_q <= STAT_NOSPACE;
							end else begin
								valid_q[slot_q] <= 1'b1;
								live_q          <= live_q + LW'(1);
								granted_q       <= 29'(x_start_q + HDR_BYTES);
								if (a_whole) begin
									ext_q   <= ext_q - EW'(1);
									total_q <= total_q - x_len_q;
								end else begin
									total_q <= total_q - need_q[29:0];
								end
							end
						end
						KIND_FREE: begin
							if (!mp && !mn && ext_q >= EW'(N)) begin
								stat_q <= STAT_FULL;
							end else begin
								valid_q[slot_q] <= 1'b0;
								live_q          <= live_q - LW'(1);
								total_q         <= total_q + sl_q;
								if (!mp && !mn) ext_q <= ext_q + EW'(1);
							end
						end
						KIND_GROW: begin
							if (!g_ok) begin
								stat_q <= STAT_NOSPACE;
							end else if (g_whole) begin
								ext_q   <= ext_q - EW'(1);
								total_q <= total_q - x_len_q;
							end else begin
								total_q <= total_q - (gsz_q[29:0] - sl_q);
							end
						end
						default: ;
					endcase
				end
				S_APPLY2: ext_q <= ext_q - EW'(1);
				default: ;
			endcase
		end
	end

	assign busy              = (state_q != S_IDLE);
	assign done              = done_q;
	assign status            = stat_q;
	assign granted_offset    = granted_q;
	assign free_total        = total_q;
	assign live_count        = 9'(live_q);
	assign free_extent_count = 7'(ext_q);

endmodule
